>>> rtl/core/wsdf_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
package wsdf_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 64;

  // Result queue depth; must be a power of two and at least 2.
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  // Header decode constants
  localparam logic [7:0] HDR_TOP_MASK  = 8'h80;
  localparam logic [7:0] HDR_OP_MASK   = 8'h0F;
  localparam logic [7:0] HDR_LEN_MASK  = 8'h7F;
  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_SHORT = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;

  typedef struct packed {
    logic        is_status;
    logic [7:0]  payload_byte;
    logic        fin_flag;
    logic [3:0]  frame_opcode;
    logic        masked_flag;
    logic [63:0] payload_length;
    logic [1:0]  parse_status;
    logic        last_result;
  } res_t;

  // Up to two results per accepted byte; v1 implies v0.
  typedef struct packed {
    logic v0;
    logic v1;
    res_t res0;
    res_t res1;
  } push_t;

endpackage

>>> rtl/core/wsdf_parser.sv
// Frame header/payload decoder: phase state plus one-byte step logic.
module wsdf_parser #(
  parameter int unsigned LENGTH_BITS = wsdf_pkg::LENGTH_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  output wsdf_pkg::push_t    push
);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_KEY,
    PH_PAY,
    PH_DONE
  } phase_t;

  localparam logic [63:0] LEN_MAX = {64{1'b1}} >> (64 - LENGTH_BITS);

  phase_t                 phase_r, phase_nxt;
  logic [3:0]             cnt_r, cnt_nxt;
  logic                   ext_long_r, ext_long_nxt;
  logic                   fin_r, fin_nxt;
  logic [3:0]             op_r, op_nxt;
  logic                   masked_r, masked_nxt;
  logic [63:0]            len_r, len_nxt;
  logic [31:0]            key_r, key_nxt;
  logic [LENGTH_BITS-1:0] ctr_r, ctr_nxt;

  logic [7:0]  key_byte;
  logic [7:0]  pay_byte;
  logic        pay_emit;
  logic [1:0]  st_code;
  wsdf_pkg::res_t pay_res, st_res;

  always_comb begin
    case (ctr_r[1:0])
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  assign pay_byte = masked_r ? (in_byte ^ key_byte) : in_byte;

  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    ext_long_nxt = ext_long_r;
    fin_nxt      = fin_r;
    op_nxt       = op_r;
    masked_nxt   = masked_r;
    len_nxt      = len_r;
    key_nxt      = key_r;
    ctr_nxt      = ctr_r;
    pay_emit     = 1'b0;
    case (phase_r)
      PH_HDR0: begin
        fin_nxt   = |(in_byte & wsdf_pkg::HDR_TOP_MASK);
        op_nxt    = 4'(in_byte & wsdf_pkg::HDR_OP_MASK);
        phase_nxt = PH_HDR1;
      end
      PH_HDR1: begin
        masked_nxt = |(in_byte & wsdf_pkg::HDR_TOP_MASK);
        if (in_byte[6:0] == wsdf_pkg::LEN_CODE_EXT16 ||
            in_byte[6:0] == wsdf_pkg::LEN_CODE_EXT64) begin
          ext_long_nxt = (in_byte[6:0] == wsdf_pkg::LEN_CODE_EXT64);
          len_nxt      = '0;
          cnt_nxt      = '0;
          phase_nxt    = PH_EXT;
        end else begin
          len_nxt = 64'(in_byte & wsdf_pkg::HDR_LEN_MASK);
          if (masked_nxt) begin
            cnt_nxt   = '0;
            phase_nxt = PH_KEY;
          end else begin
            phase_nxt = (len_nxt == '0) ? PH_DONE : PH_PAY;
          end
        end
      end
      PH_EXT: begin
        len_nxt = {len_r[55:0], in_byte};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_nxt == (ext_long_r ? 4'd8 : 4'd2)) begin
          if (len_nxt > LEN_MAX) len_nxt = LEN_MAX;
          if (masked_r) begin
            cnt_nxt   = '0;
            phase_nxt = PH_KEY;
          end else begin
            phase_nxt = (len_nxt == '0) ? PH_DONE : PH_PAY;
          end
        end
      end
      PH_KEY: begin
        key_nxt = {key_r[23:0], in_byte};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_nxt == 4'd4) phase_nxt = (len_r == '0) ? PH_DONE : PH_PAY;
      end
      PH_PAY: begin
        pay_emit = 1'b1;
        ctr_nxt  = ctr_r + 1'b1;
        // length is saturated to LENGTH_BITS, so the upper bits are zero
        if (ctr_nxt == len_r[LENGTH_BITS-1:0]) phase_nxt = PH_DONE;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (phase_nxt)
      PH_HDR0, PH_HDR1: st_code = wsdf_pkg::ST_TOO_SHORT;
      PH_DONE:          st_code = wsdf_pkg::ST_OK;
      default:          st_code = wsdf_pkg::ST_TRUNCATED;
    endcase
  end

  always_comb begin
    pay_res                = '0;
    pay_res.payload_byte   = pay_byte;
    pay_res.fin_flag       = fin_r;
    pay_res.frame_opcode   = op_r;
    pay_res.masked_flag    = masked_r;
    pay_res.payload_length = len_r;

    st_res                = '0;
    st_res.is_status      = 1'b1;
    st_res.fin_flag       = fin_nxt;
    st_res.frame_opcode   = op_nxt;
    st_res.masked_flag    = masked_nxt;
    st_res.payload_length = (phase_nxt == PH_EXT) ? 64'd0 : len_nxt;
    st_res.parse_status   = st_code;
    st_res.last_result    = 1'b1;

    push.v0   = step && (pay_emit || in_last);
    push.v1   = step && pay_emit && in_last;
    push.res0 = pay_emit ? pay_res : st_res;
    push.res1 = st_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && in_last)) begin
      phase_r    <= PH_HDR0;
      cnt_r      <= '0;
      ext_long_r <= 1'b0;
      fin_r      <= 1'b0;
      op_r       <= '0;
      masked_r   <= 1'b0;
      len_r      <= '0;
      key_r      <= '0;
      ctr_r      <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      ext_long_r <= ext_long_nxt;
      fin_r      <= fin_nxt;
      op_r       <= op_nxt;
      masked_r   <= masked_nxt;
      len_r      <= len_nxt;
      key_r      <= key_nxt;
      ctr_r      <= ctr_nxt;
    end
  end

endmodule

>>> rtl/core/wsdf_out_fifo.sv
// Small result queue taking up to two results per cycle and giving one.
module wsdf_out_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  wsdf_pkg::push_t    push,
  input  logic               pop,
  output wsdf_pkg::res_t     head,
  output logic               head_valid,
  output logic               room2
);

  localparam int unsigned PW = wsdf_pkg::RES_PTR_W;
  localparam int unsigned CW = wsdf_pkg::RES_CNT_W;

  wsdf_pkg::res_t mem_r [wsdf_pkg::RES_DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    n_push;

  assign n_push  = {1'b0, push.v0} + {1'b0, push.v1};
  assign wr_nxt  = wr_r + PW'(n_push);
  assign rd_nxt  = rd_r + PW'(pop);
  assign cnt_nxt = cnt_r + CW'(n_push) - CW'(pop);

  assign head       = mem_r[rd_r];
  assign head_valid = (cnt_r != '0);
  assign room2      = (cnt_r <= CW'(wsdf_pkg::RES_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.v0) mem_r[wr_r] <= push.res0;
    if (push.v1) mem_r[wr_r + PW'(1)] <= push.res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(wsdf_pkg::RES_DEPTH))
    else $error("result queue overfilled");
  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.v1 |-> push.v0)
    else $error("second result pushed without first");
  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push.v0 |=> cnt_r == $past(cnt_r) - CW'(1))
    else $error("queue count not decremented on pop");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("pop from empty queue");
`endif

endmodule

>>> rtl/core/websocket_frame_deframer_core.sv
// WebSocket frame deframer top level: stream ports, decoder and result queue.
//
// Usage notes:
//  - in_* carries one received buffer as bytes, one per word; in_tlast marks
//    the buffer's final byte.
//  - out_* gives result words: a payload word (out_tuser = 0) for every byte
//    inside the frame payload, unmasked, and a status word (out_tuser = 1,
//    out_tlast = 1) after the final byte of each buffer.
//  - Header bytes, extended length, mask key and bytes beyond the payload
//    produce no word of their own.
//  - Results are written to the result queue as their bytes are taken.
//  - Throughput: one byte per cycle while the queue has room. A final byte
//    that is also a payload byte yields two words, drained one per cycle.
//  - in_tready is set by the result queue (four entries) having room for two
//    words. With the receiver stalled, bytes that yield no word keep being
//    taken; the input stalls once three words wait. Nothing is dropped.
//  - Reset (rst_n low, synchronous) empties the queue and returns the decoder
//    to the first header byte; after every final byte only the decoder resets.
//  - Lengths above 2^LENGTH_BITS-1 saturate to that value.
module websocket_frame_deframer_core #(
  parameter int unsigned LENGTH_BITS = wsdf_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] payload_byte, [8] fin_flag, [12:9] frame_opcode, [13] masked_flag,
  // [77:14] payload_length, [79:78] parse_status
  output logic [79:0] out_tdata,
  output logic        out_tuser,  // is_status
  output logic        out_tlast   // last_result
);

  wsdf_pkg::push_t push;
  wsdf_pkg::res_t  head;
  logic            room2;
  logic            in_acc;
  logic            out_acc;

  assign in_tready = room2;
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;

  wsdf_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_acc),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .push    (push)
  );

  wsdf_out_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (out_acc),
    .head       (head),
    .head_valid (out_tvalid),
    .room2      (room2)
  );

  assign out_tdata = {head.parse_status, head.payload_length, head.masked_flag,
                      head.frame_opcode, head.fin_flag, head.payload_byte};
  assign out_tuser = head.is_status;
  assign out_tlast = head.last_result;

`ifndef SYNTHESIS
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == out_tlast)
    else $error("status word and last flag disagree");
  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[79:78] == wsdf_pkg::ST_OK)
    else $error("payload word carries a status code");
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[7:0] == 8'd0)
    else $error("status word carries payload data");
`endif

endmodule
